>>> src/wfp_pkg.sv
// Package for the WebSocket frame parser: phase encoding, result kinds and
// header constants. No dependencies.
package wfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 64;
    localparam int KEY_W      = 32;
    localparam int COUNT_W    = 4;
    localparam int RSV_W      = 3;
    localparam int OP_W       = 4;
    localparam int OUT_DATA_W = 88;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [COUNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [COUNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

endpackage

>>> src/websocket_frame_parser.sv
// WebSocket (base framing) frame parser, byte-wide stream in, header and
// payload results out. Depends on wfp_pkg.
//
// One frame byte is taken per clock cycle. Each request updates the header
// state and, where a result is due, loads the result register in the same
// cycle; the input is stalled only while that register is full and the
// downstream side is not ready. The critical path is the 64-bit decrement
// and zero compare of the remaining payload count. Results carry the frame's
// header fields; kind selects header, payload byte or truncated-frame error.
module websocket_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] in_byte
    input  logic [wfp_pkg::BYTE_W-1:0]    s_axis_tdata,
    // buffer_end
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] fin_bit, [3:1] reserved_bits, [7:4] op_code, [8] masked,
    // [72:9] frame_length, [80:73] out_byte, [87:81] zero
    output logic [wfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] kind
    output logic [wfp_pkg::KIND_W-1:0]    m_axis_tuser,
    // frame_end
    output logic                          m_axis_tlast
);

    wfp_pkg::t_phase                 r_phase, n_phase;
    logic [wfp_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [wfp_pkg::BYTE_W-1:0]      r_first, n_first;
    logic                            r_mask, n_mask;
    logic [wfp_pkg::LEN_W-1:0]       r_length, n_length;
    logic [wfp_pkg::LEN_W-1:0]       r_remaining, n_remaining;
    logic [wfp_pkg::KEY_W-1:0]       r_key, n_key;
    logic [1:0]                      r_key_index, n_key_index;

    logic                            r_out_valid;
    logic [wfp_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic [wfp_pkg::KIND_W-1:0]      r_out_kind;
    logic                            r_out_end;

    logic                            accept;
    logic [wfp_pkg::BYTE_W-1:0]      in_byte;
    logic                            last;
    logic                            hdr_done;
    logic                            item_done;
    logic                            err;
    logic                            do_clear;
    logic                            res_valid;
    logic [wfp_pkg::KIND_W-1:0]      res_kind;
    logic [wfp_pkg::BYTE_W-1:0]      res_byte;
    logic                            res_end;
    logic [wfp_pkg::BYTE_W-1:0]      key_byte;
    logic [wfp_pkg::OUT_DATA_W-1:0]  res_data;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign in_byte       = s_axis_tdata;
    assign last          = s_axis_tlast;

    always_comb begin
        unique case (r_key_index)
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_first     = r_first;
        n_mask      = r_mask;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_key       = r_key;
        n_key_index = r_key_index;
        hdr_done    = 1'b0;
        item_done   = 1'b0;
        err         = 1'b0;
        do_clear    = 1'b0;
        res_valid   = 1'b0;
        res_kind    = wfp_pkg::KIND_HEADER;
        res_byte    = '0;
        res_end     = 1'b0;

        unique case (r_phase)
            wfp_pkg::PH_SECOND: begin
                n_mask = in_byte[7];
                if (in_byte[6:0] == wfp_pkg::LEN_EXT16) begin
                    n_length = '0;
                    n_count  = wfp_pkg::EXT16_BYTES;
                    n_phase  = wfp_pkg::PH_EXTLEN;
                end else if (in_byte[6:0] == wfp_pkg::LEN_EXT64) begin
                    n_length = '0;
                    n_count  = wfp_pkg::EXT64_BYTES;
                    n_phase  = wfp_pkg::PH_EXTLEN;
                end else begin
                    n_length = {{(wfp_pkg::LEN_W-7){1'b0}}, in_byte[6:0]};
                    if (n_mask) begin
                        n_count = wfp_pkg::KEY_BYTES;
                        n_phase = wfp_pkg::PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            wfp_pkg::PH_EXTLEN: begin
                n_length = {r_length[wfp_pkg::LEN_W-wfp_pkg::BYTE_W-1:0], in_byte};
                n_count  = r_count - 1'b1;
                if (n_count == '0) begin
                    if (r_mask) begin
                        n_count = wfp_pkg::KEY_BYTES;
                        n_phase = wfp_pkg::PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            wfp_pkg::PH_KEY: begin
                n_key   = {r_key[wfp_pkg::KEY_W-wfp_pkg::BYTE_W-1:0], in_byte};
                n_count = r_count - 1'b1;
                if (n_count == '0) begin
                    hdr_done = 1'b1;
                end
            end
            wfp_pkg::PH_PAYLOAD: begin
                item_done   = 1'b1;
                n_key_index = r_key_index + 1'b1;
                n_remaining = r_remaining - 1'b1;
                if (n_remaining != '0 && last) begin
                    err = 1'b1;
                end else begin
                    res_valid = 1'b1;
                    res_kind  = wfp_pkg::KIND_PAYLOAD;
                    res_byte  = in_byte ^ (r_mask ? key_byte : '0);
                    res_end   = (n_remaining == '0);
                    do_clear  = res_end;
                end
            end
            default: begin
                n_count     = '0;
                n_mask      = 1'b0;
                n_length    = '0;
                n_remaining = '0;
                n_key       = '0;
                n_key_index = '0;
                n_first     = in_byte;
                n_phase     = wfp_pkg::PH_SECOND;
            end
        endcase

        if (hdr_done) begin
            if (n_length == '0) begin
                res_valid = 1'b1;
                res_end   = 1'b1;
                do_clear  = 1'b1;
            end else if (last) begin
                err = 1'b1;
            end else begin
                n_phase     = wfp_pkg::PH_PAYLOAD;
                n_remaining = n_length;
                n_key_index = '0;
                res_valid   = 1'b1;
            end
        end else if (!item_done && last) begin
            err = 1'b1;
        end

        res_data = {{(wfp_pkg::OUT_DATA_W-81){1'b0}}, res_byte, n_length, n_mask,
                    n_first[3:0], n_first[6:4], n_first[7]};

        if (err) begin
            res_valid = 1'b1;
            res_kind  = wfp_pkg::KIND_ERROR;
            res_end   = 1'b0;
            res_data  = '0;
            do_clear  = 1'b1;
        end

        if (do_clear) begin
            n_phase     = wfp_pkg::PH_FIRST;
            n_count     = '0;
            n_first     = '0;
            n_mask      = 1'b0;
            n_length    = '0;
            n_remaining = '0;
            n_key       = '0;
            n_key_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wfp_pkg::PH_FIRST;
            r_count     <= '0;
            r_first     <= '0;
            r_mask      <= 1'b0;
            r_length    <= '0;
            r_remaining <= '0;
            r_key       <= '0;
            r_key_index <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_first     <= n_first;
                r_mask      <= n_mask;
                r_length    <= n_length;
                r_remaining <= n_remaining;
                r_key       <= n_key;
                r_key_index <= n_key_index;
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_data <= res_data;
            r_out_kind <= res_kind;
            r_out_end  <= res_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_end;

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == wfp_pkg::KIND_ERROR |-> r_out_data == '0 && !r_out_end)
        else $error("error result carries non-zero fields");

    a_error_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && err |=> r_phase == wfp_pkg::PH_FIRST)
        else $error("parser did not restart after truncated frame");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == wfp_pkg::KIND_HEADER && r_out_data[72:9] == '0
        |-> r_out_end)
        else $error("zero-length header result without frame end");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == wfp_pkg::PH_PAYLOAD |-> r_remaining != '0)
        else $error("payload phase with nothing remaining");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for websocket_frame_parser: frame bytes are streamed in,
// and every header, payload and truncation result is checked against a frame decoder
// kept here. Depends on wfp_pkg and the parser RTL.
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic        masked;
        logic [63:0] len;
        logic [7:0]  data;
        logic        fend;
    } t_frame_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [wfp_pkg::BYTE_W-1:0]     s_axis_tdata = '0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [wfp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [wfp_pkg::KIND_W-1:0]     m_axis_tuser;
    logic                           m_axis_tlast;

    // {buffer_end, byte} per request, front is the one on the bus
    logic [8:0]    byte_requests[$];
    t_frame_result results_due[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    bit in_fire = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int headers_seen = 0;
    int payloads_seen = 0;
    int truncations_seen = 0;
    int frames_done = 0;

    // decoder state
    wfp_pkg::t_phase parse_phase;
    logic [3:0]      hdr_left;
    logic [7:0]      first_b;
    logic            mask_r;
    logic [63:0]     len_r;
    logic [63:0]     remain;
    logic [31:0]     key_r;
    logic [1:0]      key_idx;

    websocket_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    task automatic clear_parser();
        parse_phase = wfp_pkg::PH_FIRST;
        hdr_left = '0;
        first_b = '0;
        mask_r = 1'b0;
        len_r = '0;
        remain = '0;
        key_r = '0;
        key_idx = '0;
    endtask

    function automatic t_frame_result frame_fields(logic [1:0] k, logic [7:0] d, logic e);
        t_frame_result r;
        r.kind = k;
        r.fin = first_b[7];
        r.rsv = first_b[6:4];
        r.op = first_b[3:0];
        r.masked = mask_r;
        r.len = len_r;
        r.data = d;
        r.fend = e;
        return r;
    endfunction

    task automatic push_truncation();
        t_frame_result r;
        r = '0;
        r.kind = wfp_pkg::KIND_ERROR;
        results_due.push_back(r);
        clear_parser();
    endtask

    task automatic decode_frame_byte(input logic [7:0] b, input logic last);
        logic       hdr_done;
        logic       settled;
        logic [7:0] key_b;
        hdr_done = 1'b0;
        settled = 1'b0;
        case (parse_phase)
            wfp_pkg::PH_SECOND: begin
                mask_r = b[7];
                if (b[6:0] == wfp_pkg::LEN_EXT16) begin
                    len_r = '0;
                    hdr_left = wfp_pkg::EXT16_BYTES;
                    parse_phase = wfp_pkg::PH_EXTLEN;
                end else if (b[6:0] == wfp_pkg::LEN_EXT64) begin
                    len_r = '0;
                    hdr_left = wfp_pkg::EXT64_BYTES;
                    parse_phase = wfp_pkg::PH_EXTLEN;
                end else begin
                    len_r = 64'(b[6:0]);
                    if (mask_r) begin
                        hdr_left = wfp_pkg::KEY_BYTES;
                        parse_phase = wfp_pkg::PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            wfp_pkg::PH_EXTLEN: begin
                len_r = {len_r[55:0], b};
                hdr_left = hdr_left - 1'b1;
                if (hdr_left == '0) begin
                    if (mask_r) begin
                        hdr_left = wfp_pkg::KEY_BYTES;
                        parse_phase = wfp_pkg::PH_KEY;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            wfp_pkg::PH_KEY: begin
                key_r = {key_r[23:0], b};
                hdr_left = hdr_left - 1'b1;
                if (hdr_left == '0) hdr_done = 1'b1;
            end
            wfp_pkg::PH_PAYLOAD: begin
                key_b = mask_r ? key_r[31 - 8*key_idx -: 8] : 8'h00;
                key_idx = key_idx + 1'b1;
                remain = remain - 64'd1;
                settled = 1'b1;
                if (remain != '0 && last) begin
                    push_truncation();
                end else begin
                    results_due.push_back(frame_fields(wfp_pkg::KIND_PAYLOAD, b ^ key_b,
                                                       remain == '0));
                    if (remain == '0) clear_parser();
                end
            end
            default: begin
                clear_parser();
                first_b = b;
                parse_phase = wfp_pkg::PH_SECOND;
            end
        endcase
        if (hdr_done) begin
            settled = 1'b1;
            if (len_r == '0) begin
                results_due.push_back(frame_fields(wfp_pkg::KIND_HEADER, 8'h00, 1'b1));
                clear_parser();
            end else if (last) begin
                push_truncation();
            end else begin
                parse_phase = wfp_pkg::PH_PAYLOAD;
                remain = len_r;
                key_idx = '0;
                results_due.push_back(frame_fields(wfp_pkg::KIND_HEADER, 8'h00, 1'b0));
            end
        end
        if (!settled && last) push_truncation();
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // monitor: take requests into the decoder and check results
    always @(posedge i_clk) begin : monitor
        t_frame_result exp_r;
        cycle_count++;
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            decode_frame_byte(s_axis_tdata, s_axis_tlast);
            bytes_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (results_due.size() == 0) begin
                $error("result with no expectation pending: tuser 0x%0h tdata 0x%0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                exp_r = results_due.pop_front();
                check_field("kind", 64'(exp_r.kind), 64'(m_axis_tuser));
                check_field("fin_bit", 64'(exp_r.fin), 64'(m_axis_tdata[0]));
                check_field("reserved_bits", 64'(exp_r.rsv), 64'(m_axis_tdata[3:1]));
                check_field("op_code", 64'(exp_r.op), 64'(m_axis_tdata[7:4]));
                check_field("masked", 64'(exp_r.masked), 64'(m_axis_tdata[8]));
                check_field("frame_length", exp_r.len, m_axis_tdata[72:9]);
                check_field("out_byte", 64'(exp_r.data), 64'(m_axis_tdata[80:73]));
                check_field("frame_end", 64'(exp_r.fend), 64'(m_axis_tlast));
                if (exp_r.kind == wfp_pkg::KIND_HEADER) headers_seen++;
                if (exp_r.kind == wfp_pkg::KIND_PAYLOAD) payloads_seen++;
                if (exp_r.kind == wfp_pkg::KIND_ERROR) truncations_seen++;
                if (exp_r.fend) frames_done++;
            end
        end
    end

    // driver: hold a request until taken, then advance
    always @(negedge i_clk) begin : driver
        if (in_fire) void'(byte_requests.pop_front());
        if (s_axis_tvalid && !in_fire) begin
            s_axis_tvalid <= 1'b1;
        end else if (i_rst_n && byte_requests.size() > 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= byte_requests[0][7:0];
            s_axis_tlast  <= byte_requests[0][8];
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_req(logic [7:0] b, logic last);
        byte_requests.push_back({last, b});
    endtask

    task automatic queue_random_frame(output int pushed);
        logic [7:0]  frame_bytes[$];
        logic [63:0] plen;
        logic [6:0]  code;
        logic        mask;
        int          sel;
        int          ext_n;
        int          send_n;
        int          cut;
        int          n;
        bit          whole;
        bit          truncate;
        frame_bytes = {};
        pushed = 0;
        if ($urandom_range(99) < 10) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) push_req(8'($urandom), $urandom_range(3) == 0);
            pushed = n;
        end else begin
            mask = 1'($urandom_range(1));
            sel = $urandom_range(99);
            ext_n = 0;
            if (sel < 60) begin
                plen = 64'($urandom_range(0, 16));
                code = plen[6:0];
            end else if (sel < 72) begin
                plen = 64'($urandom_range(0, 125));
                code = plen[6:0];
            end else if (sel < 92) begin
                code = wfp_pkg::LEN_EXT16;
                ext_n = 2;
                plen = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 65535))
                                                 : 64'($urandom_range(0, 40));
            end else begin
                code = wfp_pkg::LEN_EXT64;
                ext_n = 8;
                plen = $urandom_range(1) ? {$urandom, $urandom} : 64'($urandom_range(0, 30));
            end
            frame_bytes.push_back(8'($urandom));
            frame_bytes.push_back({mask, code});
            for (int i = ext_n - 1; i >= 0; i--) frame_bytes.push_back(plen[8*i +: 8]);
            if (mask) repeat (4) frame_bytes.push_back(8'($urandom));
            whole = (plen <= 64'd40) || (plen <= 64'd300 && $urandom_range(7) == 0);
            send_n = whole ? int'(plen) : $urandom_range(0, 40);
            repeat (send_n) frame_bytes.push_back(8'($urandom));
            n = frame_bytes.size();
            truncate = !whole || ($urandom_range(99) < 12);
            if (!whole) cut = n - 1;
            else if (truncate) cut = $urandom_range(0, n - 2);
            else cut = n - 1;
            for (int i = 0; i <= cut; i++)
                push_req(frame_bytes[i], (i == cut) && (truncate || $urandom_range(1)));
            pushed = cut + 1;
        end
    endtask

    task automatic wait_drain();
        while (byte_requests.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : timeout
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int k;
        int generated;
        clear_parser();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short unmasked text frame, buffer ends on its final byte
        push_req(8'h81, 1'b0); push_req(8'h02, 1'b0);
        push_req(8'h00, 1'b0); push_req(8'hFF, 1'b1);
        // empty ping with buffer end on the header
        push_req(8'h89, 1'b0); push_req(8'h00, 1'b1);
        // masked frame, all reserved bits set
        push_req(8'h7A, 1'b0); push_req(8'h81, 1'b0);
        push_req(8'hFF, 1'b0); push_req(8'h00, 1'b0);
        push_req(8'hAA, 1'b0); push_req(8'h55, 1'b0);
        push_req(8'h3C, 1'b0);
        // 64-bit length with top bit set, buffer ends as the header completes
        push_req(8'h0F, 1'b0); push_req(8'h7F, 1'b0);
        for (int i = 0; i < 8; i++) push_req(8'hFF, i == 7);
        // buffer ends on the first header byte
        push_req(8'h00, 1'b1);
        wait_drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_left = 300;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 88;
                end
                default: begin
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
            endcase
            generated = 0;
            while (generated < 120) begin
                queue_random_frame(k);
                generated += k;
            end
            wait_drain();
        end

        $display("Run covered %0d request bytes and %0d results over four idling phases",
                 bytes_taken, results_seen);
        $display("with a long output hold-off: %0d headers, %0d payload bytes,",
                 headers_seen, payloads_seen);
        $display("%0d truncations, %0d frames completed.", truncations_seen, frames_done);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
src/wfp_pkg.sv
src/websocket_frame_parser.sv
tb/sv/testbench.sv
